@@ sv/ksgsba_pkg.sv @@
package ksgsba_pkg;

	localparam int WORD_W = 64;
	localparam int UQ_W = 63;
	localparam int WGT_W = 33;
	localparam int NODE_W = 3;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CB_TWO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z = 2'd3;

	// point queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// root unit step counts (2 bits per step for sqrt, 3 for cbrt)
	localparam int SQRT_STEPS = 48;
	localparam int CBRT_STEPS = 43;
	localparam int ROOT_CNT_W = 6;

	localparam logic signed [WORD_W-1:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [WORD_W-1:0] Q_MIN = 64'sh8000_0000_0000_0000;

	// one finished point handed from front to back
	typedef struct packed {
		logic signed [WORD_W-1:0] tke;
		logic signed [WORD_W-1:0] vol;
		logic signed [WORD_W-1:0] gx;
		logic signed [WORD_W-1:0] gy;
		logic signed [WORD_W-1:0] gz;
		logic [UQ_W-1:0]          subv;
		logic [NODE_W-1:0]        node;
	} point_t;

	function automatic logic signed [WORD_W-1:0] qadd(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W-1:0] r;
		r = a + b;
		if (a[WORD_W-1] == b[WORD_W-1] && r[WORD_W-1] != a[WORD_W-1])
			r = a[WORD_W-1] ? Q_MIN : Q_MAX;
		return r;
	endfunction

	function automatic logic signed [WORD_W-1:0] qsub(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W-1:0] r;
		r = a - b;
		if (a[WORD_W-1] != b[WORD_W-1] && r[WORD_W-1] != a[WORD_W-1])
			r = a[WORD_W-1] ? Q_MIN : Q_MAX;
		return r;
	endfunction

endpackage

@@ sv/ksgsba_if.sv @@
interface ksgsba_in_if;
	logic                valid;
	logic                ready;
	logic [32:0]         shape_weight;
	logic [62:0]         node_tke;
	logic [62:0]         node_dual_volume;
	logic [62:0]         node_density;
	logic signed [63:0]  grad_weight_x;
	logic signed [63:0]  grad_weight_y;
	logic signed [63:0]  grad_weight_z;
	logic [62:0]         sub_volume;
	logic [2:0]          target_node;
	logic                last_node;

	modport source(output valid, shape_weight, node_tke, node_dual_volume, node_density,
		grad_weight_x, grad_weight_y, grad_weight_z, sub_volume, target_node, last_node,
		input ready);
	modport sink(input valid, shape_weight, node_tke, node_dual_volume, node_density,
		grad_weight_x, grad_weight_y, grad_weight_z, sub_volume, target_node, last_node,
		output ready);
endinterface

interface ksgsba_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         out_node;
	logic signed [63:0] source_value;

	modport source(output valid, out_node, source_value, input ready);
	modport sink(input valid, out_node, source_value, output ready);
endinterface

@@ sv/ksgsba_qmul.sv @@
module ksgsba_qmul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ksgsba_pkg::WORD_W-1:0] a,
	input  logic signed [ksgsba_pkg::WORD_W-1:0] b,
	output logic                               done,
	output logic signed [ksgsba_pkg::WORD_W-1:0] y
);
	import ksgsba_pkg::*;

	logic [WORD_W-1:0]   ma_q, mb_q;
	logic                neg_q;
	logic [2*WORD_W-1:0] acc_q;
	logic [1:0]          cnt_q;
	logic                run_q, fin_q, done_q;
	logic signed [WORD_W-1:0] y_q;

	logic [31:0]         ah, bh;
	logic [63:0]         pp;
	logic [6:0]          sh;
	logic [2*WORD_W-1:0] pp_sh, rr;
	logic [WORD_W-1:0]   lim, qv;

	// one 32x32 partial product per cycle
	always_comb begin
		ah = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
		bh = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp = ah * bh;
		sh = (cnt_q[0] && cnt_q[1]) ? 7'd64 : ((cnt_q[0] || cnt_q[1]) ? 7'd32 : 7'd0);
		pp_sh = {64'd0, pp} << sh;
	end

	// round the magnitude half up and saturate; the sign goes on when y_q is loaded
	always_comb begin
		rr = acc_q + 128'h8000_0000;
		lim = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		qv = (rr[127:96] != 32'd0) ? lim : rr[95:32];
		if (qv > lim)
			qv = lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				fin_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operand and accumulator datapath
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[WORD_W-1] ? (~a + 64'd1) : a;
			mb_q <= b[WORD_W-1] ? (~b + 64'd1) : b;
			neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (fin_q)
			y_q <= neg_q ? (~qv + 64'd1) : qv;
	end

	assign done = done_q;
	assign y = y_q;
endmodule

@@ sv/ksgsba_root.sv @@
module ksgsba_root (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               cube,
	input  logic signed [ksgsba_pkg::WORD_W-1:0] x,
	output logic                               done,
	output logic signed [ksgsba_pkg::WORD_W-1:0] y
);
	import ksgsba_pkg::*;

	logic [128:0]            rad_q;
	logic [91:0]             rem_q, r2_q;
	logic [47:0]             r_q;
	logic [ROOT_CNT_W-1:0]   cnt_q;
	logic                    run_q, done_q, cube_q;

	logic [91:0] remx, t, ts, tc, sc, r2n, remx_s, remx_c;
	logic [47:0] rn;
	logic        take;

	// one result bit per step: 2 radicand bits for sqrt, 3 for cbrt
	always_comb begin
		rn = {r_q[46:0], 1'b0};
		remx_s = {rem_q[89:0], rad_q[128:127]};
		remx_c = {rem_q[88:0], rad_q[128:126]};
		ts = {43'd0, rn, 1'b1};
		r2n = {r2_q[89:0], 2'b00};
		sc = r2n + {44'd0, rn};
		tc = {sc[90:0], 1'b0} + sc + 92'd1;
		remx = cube_q ? remx_c : remx_s;
		t = cube_q ? tc : ts;
		take = (remx >= t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= cube ? ROOT_CNT_W'(CBRT_STEPS) : ROOT_CNT_W'(SQRT_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - ROOT_CNT_W'(1);
				if (cnt_q == ROOT_CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// radicand, remainder and partial root; a non-positive input gives zero
	always_ff @(posedge clk) begin
		if (start) begin
			cube_q <= cube;
			rem_q <= '0;
			r2_q <= '0;
			r_q <= '0;
			if (x[WORD_W-1] || x == '0)
				rad_q <= '0;
			else if (cube)
				rad_q <= {1'b0, x, 64'd0};
			else
				rad_q <= {x, 65'd0};
		end else if (run_q) begin
			rad_q <= cube_q ? {rad_q[125:0], 3'b000} : {rad_q[126:0], 2'b00};
			if (take) begin
				rem_q <= remx - t;
				r_q <= rn | 48'd1;
				r2_q <= r2n + {43'd0, rn, 1'b0} + 92'd1;
			end else begin
				rem_q <= remx;
				r_q <= rn;
				r2_q <= r2n;
			end
		end
	end

	assign done = done_q;
	assign y = {16'd0, r_q};
endmodule

@@ sv/ksgsba_front.sv @@
module ksgsba_front (
	input  logic                clk,
	input  logic                arst_n,
	ksgsba_in_if.sink           in_ch,
	input  logic                q_full,
	output logic                q_push,
	output ksgsba_pkg::point_t  q_data
);
	import ksgsba_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0] state_q;
	logic signed [WORD_W-1:0] tke_q, vol_q, gx_q, gy_q, gz_q;
	logic [UQ_W-1:0]   subv_q;
	logic [NODE_W-1:0] node_q;
	logic              last_q;

	logic start;
	logic [4:0] done;
	logic signed [WORD_W-1:0] p_tke, p_vol, p_gx, p_gy, p_gz;

	assign in_ch.ready = (state_q == F_IDLE);
	assign start = in_ch.valid && in_ch.ready;

	// five products per beat in parallel
	ksgsba_qmul u_mul_tke (.clk, .arst_n, .start,
		.a({31'd0, in_ch.shape_weight}), .b({1'b0, in_ch.node_tke}),
		.done(done[0]), .y(p_tke));
	ksgsba_qmul u_mul_vol (.clk, .arst_n, .start,
		.a({31'd0, in_ch.shape_weight}), .b({1'b0, in_ch.node_dual_volume}),
		.done(done[1]), .y(p_vol));
	ksgsba_qmul u_mul_gx (.clk, .arst_n, .start,
		.a(in_ch.grad_weight_x), .b({1'b0, in_ch.node_density}),
		.done(done[2]), .y(p_gx));
	ksgsba_qmul u_mul_gy (.clk, .arst_n, .start,
		.a(in_ch.grad_weight_y), .b({1'b0, in_ch.node_density}),
		.done(done[3]), .y(p_gy));
	ksgsba_qmul u_mul_gz (.clk, .arst_n, .start,
		.a(in_ch.grad_weight_z), .b({1'b0, in_ch.node_density}),
		.done(done[4]), .y(p_gz));

	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = '{tke: tke_q, vol: vol_q, gx: gx_q, gy: gy_q, gz: gz_q,
		subv: subv_q, node: node_q};

	// accumulate, hand the point over on the last beat, then clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			tke_q <= '0;
			vol_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
			gz_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start)
						state_q <= F_MUL;
				end
				F_MUL: begin
					if (&done) begin
						tke_q <= qadd(tke_q, p_tke);
						vol_q <= qadd(vol_q, p_vol);
						gx_q <= qadd(gx_q, p_gx);
						gy_q <= qadd(gy_q, p_gy);
						gz_q <= qadd(gz_q, p_gz);
						state_q <= last_q ? F_PUSH : F_IDLE;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						tke_q <= '0;
						vol_q <= '0;
						gx_q <= '0;
						gy_q <= '0;
						gz_q <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// per point fields from the accepted beat
	always_ff @(posedge clk) begin
		if (start) begin
			last_q <= in_ch.last_node;
			subv_q <= in_ch.sub_volume;
			node_q <= in_ch.target_node;
		end
	end
endmodule

@@ sv/ksgsba_queue.sv @@
module ksgsba_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ksgsba_pkg::point_t  push_data,
	input  logic                pop,
	output ksgsba_pkg::point_t  head,
	output logic                full,
	output logic                empty
);
	import ksgsba_pkg::*;

	point_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// pointers wrap at the queue depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end
endmodule

@@ sv/ksgsba_back.sv @@
module ksgsba_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  ksgsba_pkg::point_t                 q_head,
	output logic                               q_pop,
	input  logic [ksgsba_pkg::UQ_W-1:0]        cb_two,
	input  logic signed [ksgsba_pkg::WORD_W-1:0] grav_x,
	input  logic signed [ksgsba_pkg::WORD_W-1:0] grav_y,
	input  logic signed [ksgsba_pkg::WORD_W-1:0] grav_z,
	ksgsba_out_if.source                       out_ch
);
	import ksgsba_pkg::*;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_MGO   = 3'd1;
	localparam logic [2:0] B_MWAIT = 3'd2;
	localparam logic [2:0] B_RGO   = 3'd3;
	localparam logic [2:0] B_RWAIT = 3'd4;
	localparam logic [2:0] B_OUT   = 3'd5;

	// product sequence
	localparam logic [3:0] S_CX_A = 4'd0;
	localparam logic [3:0] S_CX_B = 4'd1;
	localparam logic [3:0] S_CY_A = 4'd2;
	localparam logic [3:0] S_CY_B = 4'd3;
	localparam logic [3:0] S_CZ_A = 4'd4;
	localparam logic [3:0] S_CZ_B = 4'd5;
	localparam logic [3:0] S_SQ_X = 4'd6;
	localparam logic [3:0] S_SQ_Y = 4'd7;
	localparam logic [3:0] S_SQ_Z = 4'd8;
	localparam logic [3:0] S_DOT_X = 4'd9;
	localparam logic [3:0] S_DOT_Y = 4'd10;
	localparam logic [3:0] S_DOT_Z = 4'd11;
	localparam logic [3:0] S_T_CB = 4'd12;
	localparam logic [3:0] S_T_TKE = 4'd13;
	localparam logic [3:0] S_T_S = 4'd14;
	localparam logic [3:0] S_T_SUB = 4'd15;

	logic [2:0] state_q;
	logic [3:0] step_q;
	point_t     pt_q;
	logic signed [WORD_W-1:0] acc_q, cx_q, cy_q, cz_q, mag_q, dot_q, t_q, root_q;
	logic       ovalid_q;
	logic [NODE_W-1:0] onode_q;
	logic signed [WORD_W-1:0] oval_q;

	logic signed [WORD_W-1:0] ma, mb, p, rx, ry;
	logic m_done, r_done, r_cube, load_out;

	// operand select for the current product
	always_comb begin
		unique case (step_q)
			S_CX_A:  begin ma = pt_q.gy; mb = grav_z; end
			S_CX_B:  begin ma = pt_q.gz; mb = grav_y; end
			S_CY_A:  begin ma = pt_q.gz; mb = grav_x; end
			S_CY_B:  begin ma = pt_q.gx; mb = grav_z; end
			S_CZ_A:  begin ma = pt_q.gx; mb = grav_y; end
			S_CZ_B:  begin ma = pt_q.gy; mb = grav_x; end
			S_SQ_X:  begin ma = cx_q; mb = cx_q; end
			S_SQ_Y:  begin ma = cy_q; mb = cy_q; end
			S_SQ_Z:  begin ma = cz_q; mb = cz_q; end
			S_DOT_X: begin ma = pt_q.gx; mb = grav_x; end
			S_DOT_Y: begin ma = pt_q.gy; mb = grav_y; end
			S_DOT_Z: begin ma = pt_q.gz; mb = grav_z; end
			S_T_CB:  begin ma = {1'b0, cb_two}; mb = root_q; end
			S_T_TKE: begin ma = t_q; mb = root_q; end
			S_T_S:   begin ma = t_q; mb = qsub(mag_q, dot_q); end
			S_T_SUB: begin ma = t_q; mb = {1'b0, pt_q.subv}; end
			default: begin ma = t_q; mb = t_q; end
		endcase
	end

	// root select: magnitude of the gradient-gravity cross product, cube root of volume, sqrt of tke
	always_comb begin
		priority if (step_q == S_SQ_Z) begin
			rx = acc_q;
			r_cube = 1'b0;
		end else if (step_q == S_DOT_Z) begin
			rx = pt_q.vol;
			r_cube = 1'b1;
		end else begin
			rx = pt_q.tke;
			r_cube = 1'b0;
		end
	end

	ksgsba_qmul u_mul (.clk, .arst_n, .start(state_q == B_MGO), .a(ma), .b(mb),
		.done(m_done), .y(p));
	ksgsba_root u_root (.clk, .arst_n, .start(state_q == B_RGO), .cube(r_cube), .x(rx),
		.done(r_done), .y(ry));

	assign q_pop = (state_q == B_IDLE) && !q_empty;
	assign load_out = (state_q == B_OUT) && (!ovalid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= S_CX_A;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out)
				ovalid_q <= 1'b1;
			else if (out_ch.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						step_q <= S_CX_A;
						state_q <= B_MGO;
					end
				end
				B_MGO: state_q <= B_MWAIT;
				B_MWAIT: begin
					if (m_done) begin
						priority if (step_q == S_SQ_Z || step_q == S_DOT_Z ||
							step_q == S_T_CB)
							state_q <= B_RGO;
						else if (step_q == S_T_SUB)
							state_q <= B_OUT;
						else begin
							step_q <= step_q + 4'd1;
							state_q <= B_MGO;
						end
					end
				end
				B_RGO: state_q <= B_RWAIT;
				B_RWAIT: begin
					if (r_done) begin
						step_q <= step_q + 4'd1;
						state_q <= B_MGO;
					end
				end
				B_OUT: begin
					if (load_out)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath: what each finished product feeds
	always_ff @(posedge clk) begin
		if (q_pop)
			pt_q <= q_head;
		if (state_q == B_MWAIT && m_done) begin
			unique case (step_q)
				S_CX_A, S_CY_A, S_CZ_A, S_SQ_X: acc_q <= p;
				S_CX_B: cx_q <= qsub(acc_q, p);
				S_CY_B: cy_q <= qsub(acc_q, p);
				S_CZ_B: cz_q <= qsub(acc_q, p);
				S_SQ_Y, S_SQ_Z: acc_q <= qadd(acc_q, p);
				S_DOT_X: dot_q <= p;
				S_DOT_Y, S_DOT_Z: dot_q <= qadd(dot_q, p);
				S_T_CB, S_T_TKE, S_T_S, S_T_SUB: t_q <= p;
				default: t_q <= p;
			endcase
		end
		if (state_q == B_RWAIT && r_done) begin
			root_q <= ry;
			if (step_q == S_SQ_Z)
				mag_q <= ry;
		end
		if (load_out) begin
			onode_q <= pt_q.node;
			oval_q <= t_q;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.out_node = onode_q;
	assign out_ch.source_value = oval_q;
endmodule

@@ sv/ksgs_buoyancy_source_accumulator_core.sv @@
// Buoyancy source accumulator, signed Q32.32 with saturation. The front takes one node beat
// at a time and accepts the next only once the running sums hold its products: its five
// products each run on a 32x32 multiplier with a start step, four partial products and a
// rounding step, and the running sums update in the cycle after they finish. The beat
// flagged last_node then hands its point to a two-entry queue, waiting while it is full.
// The back drains that queue one point at a time through a single shared multiplier (16
// products) and a digit-serial root unit (48 steps per square root, 43 per cube root). This
// overlaps with accumulation of the next points while the queue has room. The result sits
// in an output register, so the back moves on while it waits.
module ksgs_buoyancy_source_accumulator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ksgsba_in_if.sink                            in_ch,
	ksgsba_out_if.source                         out_ch,
	input  logic                                 cfg_we,
	input  logic [ksgsba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ksgsba_pkg::WORD_W-1:0]        cfg_data
);
	import ksgsba_pkg::*;

	logic [UQ_W-1:0]          cb_two_q;
	logic signed [WORD_W-1:0] grav_x_q, grav_y_q, grav_z_q;

	point_t q_in, q_head;
	logic   q_push, q_pop, q_full, q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_two_q <= '0;
			grav_x_q <= '0;
			grav_y_q <= '0;
			grav_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CB_TWO: cb_two_q <= cfg_data[UQ_W-1:0];
				CFG_GRAV_X: grav_x_q <= cfg_data;
				CFG_GRAV_Y: grav_y_q <= cfg_data;
				CFG_GRAV_Z: grav_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ksgsba_front u_front (.clk, .arst_n, .in_ch, .q_full, .q_push, .q_data(q_in));

	ksgsba_queue u_queue (.clk, .arst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
		.head(q_head), .full(q_full), .empty(q_empty));

	ksgsba_back u_back (.clk, .arst_n, .q_empty, .q_head, .q_pop, .cb_two(cb_two_q),
		.grav_x(grav_x_q), .grav_y(grav_y_q), .grav_z(grav_z_q), .out_ch);
endmodule

@@ sv/ksgsba_checker.sv @@
module ksgsba_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] source_value
);
	// a pending result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(source_value))
		else $error("result value changed while stalled");

	// the front is busy multiplying right after a beat
	a_in_busy1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again during accumulation");

	a_in_busy3: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##3 !in_ready)
		else $error("accumulation ended too early");
endmodule

bind ksgs_buoyancy_source_accumulator_core ksgsba_props u_props (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.source_value(out_ch.source_value)
);
